// File: sv/assert_macros.svh
// Assertion macros shared by the compander RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: sv/spl_pkg.sv
// Constants and elaboration-time helpers for the spectral power-law compander.
// No dependencies; used by the cells, the scaler and the top level.
package spl_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int LOG_FRAC         = 24;
    localparam int MANT_FRAC        = 30;
    localparam int MANT_W           = MANT_FRAC + 1;
    localparam int SHIFT_W          = 18;
    localparam int LINT_W           = 8;

    localparam logic signed [25:0] EXP_COMPRESS = -26'sd5872026;
    localparam logic signed [25:0] EXP_EXPAND   = 26'sd19573419;

    // Truncated integer square root, used only on constants.
    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Factor 2^(2^-idx) in Q1.30, as a chain of truncated square roots from 2.0.
    function automatic logic [MANT_W-1:0] exp2_factor(input int idx);
        logic [63:0] c;
        c = 64'd1 << (MANT_FRAC + 1);
        for (int i = 1; i <= idx; i++) begin
            c = isqrt64(c << MANT_FRAC);
        end
        return c[MANT_W-1:0];
    endfunction

endpackage

// File: sv/spl_log_cell.sv
// One bit of the base-two logarithm fraction: square, renormalise, emit a bit.
// Depends on spl_pkg.
module spl_log_cell (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [spl_pkg::MANT_W-1:0]    y_in,
    input  logic [spl_pkg::LOG_FRAC-1:0]  frac_in,
    output logic [spl_pkg::MANT_W-1:0]    y_out,
    output logic [spl_pkg::LOG_FRAC-1:0]  frac_out
);
    import spl_pkg::*;

    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     ysq;
    logic                bit_v;
    logic [MANT_W-1:0]   y_next;
    logic [MANT_W-1:0]   y_reg;
    logic [LOG_FRAC-1:0] frac_reg;

    always_comb begin
        sq     = y_in * y_in;
        ysq    = sq[MANT_FRAC +: MANT_W+1];
        bit_v  = ysq[MANT_W];
        y_next = bit_v ? ysq[MANT_W:1] : ysq[MANT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg    <= y_next;
            frac_reg <= {frac_in[LOG_FRAC-2:0], bit_v};
        end
    end

    assign y_out    = y_reg;
    assign frac_out = frac_reg;
endmodule

// File: sv/spl_exp_cell.sv
// One factor of the base-two power of a fraction: multiply in 2^(2^-IDX) if its bit is set.
// Depends on spl_pkg.
module spl_exp_cell #(
    parameter int IDX = 1
) (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [spl_pkg::MANT_W-1:0]    m_in,
    input  logic [spl_pkg::LOG_FRAC-1:0]  f_in,
    output logic [spl_pkg::MANT_W-1:0]    m_out,
    output logic [spl_pkg::LOG_FRAC-1:0]  f_out
);
    import spl_pkg::*;

    localparam logic [MANT_W-1:0] FACTOR = exp2_factor(IDX);

    logic [2*MANT_W:0]   prod;
    logic [MANT_W-1:0]   m_next;
    logic [MANT_W-1:0]   m_reg;
    logic [LOG_FRAC-1:0] f_reg;

    always_comb begin
        prod   = (2*MANT_W+1)'(m_in) * (2*MANT_W+1)'(FACTOR)
                 + ((2*MANT_W+1)'(1) << (MANT_FRAC - 1));
        m_next = f_in[LOG_FRAC-IDX] ? prod[MANT_FRAC +: MANT_W] : m_in;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg <= m_next;
            f_reg <= f_in;
        end
    end

    assign m_out = m_reg;
    assign f_out = f_reg;
endmodule

// File: sv/spl_scale.sv
// Scales one part's magnitude by the mantissa, shifts with rounding, saturates, restores sign.
// Depends on spl_pkg; two register stages.
module spl_scale #(
    parameter int SAMPLE_WIDTH = spl_pkg::SAMPLE_WIDTH_DEF,
    parameter int MW           = spl_pkg::MANT_W
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [SAMPLE_WIDTH-1:0]           mag,
    input  logic                              neg,
    input  logic [MW-1:0]                     mant,
    input  logic signed [spl_pkg::SHIFT_W-1:0] rsh,
    output logic [SAMPLE_WIDTH-1:0]           part,
    output logic                              sat
);
    import spl_pkg::*;

    localparam int PW = SAMPLE_WIDTH + MW;

    logic [PW-1:0]             prod_reg;
    logic signed [SHIFT_W-1:0] r_reg;
    logic                      neg_reg;
    logic [SAMPLE_WIDTH-1:0]   part_reg;
    logic                      sat_reg;

    logic [63:0]               p64;
    logic [63:0]               lim;
    logic [64:0]               sum;
    logic [63:0]               q;
    logic signed [SHIFT_W-1:0] l;
    logic                      clip;
    logic [63:0]               q_fin;
    logic [SAMPLE_WIDTH-1:0]   part_next;

    always_comb begin
        p64 = 64'(prod_reg);
        lim = (64'd1 << (SAMPLE_WIDTH - 1)) - (neg_reg ? 64'd0 : 64'd1);
        l   = -r_reg;
        sum = 65'd0;
        if (r_reg > 0) begin
            if (r_reg > 63) begin
                q = 64'd0;
            end else begin
                sum = {1'b0, p64} + (65'd1 << (r_reg - 1));
                q   = 64'(sum >> r_reg);
            end
        end else if (p64 == 64'd0) begin
            q = 64'd0;
        end else if (l >= 63 || p64 > (lim >> l)) begin
            q = lim + 64'd1;
        end else begin
            q = p64 << l;
        end
        clip      = q > lim;
        q_fin     = clip ? lim : q;
        part_next = neg_reg ? SAMPLE_WIDTH'(-q_fin) : SAMPLE_WIDTH'(q_fin);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(mag) * PW'(mant);
            r_reg    <= rsh;
            neg_reg  <= neg;
            part_reg <= part_next;
            sat_reg  <= clip;
        end
    end

    assign part = part_reg;
    assign sat  = sat_reg;
endmodule

// File: sv/spectral_power_law_compander.sv
// Top level of the spectral power-law compander: front end, logarithm and power cell rows,
// scalers. Depends on spl_pkg, spl_log_cell, spl_exp_cell, spl_scale and assert_macros.svh.
//
//  channel | direction | tdata (low bit up)     | tuser
//  s_      | in        | bin_re, bin_im         | func
//  m_      | out       | out_re, out_im         | saturated
//
// One word is taken every cycle while the output is not stalled.
// The latency is set mostly by the two rows of 24 cells for the logarithm and the power.
// A stalled output holds the whole pipeline; s_tready is low only while a result waits.
// Reset clears the valid line only; no clearing pass is needed.
`include "assert_macros.svh"
module spectral_power_law_compander #(
    parameter int SAMPLE_WIDTH = spl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,  // bin_re, bin_im, zero pad
    input  logic [7:0]                            s_tuser,  // func, zero pad
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,  // out_re, out_im, zero pad
    output logic [7:0]                            m_tuser   // saturated, zero pad
);
    import spl_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int TDW   = ((2*W+7)/8)*8;
    localparam int SMAX  = W > 31 ? W - 31 : 0;
    localparam int MSH   = W > 32 ? W - 32 : 0;
    localparam int MW    = MANT_W - MSH;
    localparam int NCELL = LOG_FRAC;
    localparam int LAST  = 57;

    logic en;
    logic [LAST:0] vld_reg;

    logic [W-1:0] mre_reg [0:56];
    logic [W-1:0] mim_reg [0:56];
    logic         nre_reg [0:56];
    logic         nim_reg [0:56];
    logic         zer_reg [0:56];
    logic         exp_reg [0:56];

    logic [MANT_W-1:0]   a1_reg, b1_reg;
    logic [5:0]          s1_reg, s2_reg, s3_reg;
    logic [62:0]         p2_reg, p3_reg;
    logic [5:0]          n3_reg;
    logic [MANT_W-1:0]   y4_reg;
    logic signed [LINT_W-1:0] lint_reg [4:28];
    logic signed [63:0]  z_reg;
    logic signed [SHIFT_W-1:0] k_reg [30:54];
    logic [LOG_FRAC-1:0] f30_reg;

    logic [MANT_W-1:0]   y_c [0:NCELL];
    logic [LOG_FRAC-1:0] fr_c [0:NCELL];
    logic [MANT_W-1:0]   m_c [0:NCELL];
    logic [LOG_FRAC-1:0] fe_c [0:NCELL];

    logic [W-1:0] in_re, in_im, mag_re_in, mag_im_in;
    logic [W-1:0] orr_reg, oim_reg;
    logic         osat_reg;

    logic [63:0]  v_or, a_ext, b_ext;
    logic [5:0]   s_next, n_next;
    logic [MANT_W-1:0] y_next;
    logic signed [LINT_W-1:0] lint_next;
    logic signed [31:0] lval;
    logic signed [63:0] z_next;
    logic [63:0]  g_next;
    logic [W-1:0] part_re, part_im;
    logic         sat_re, sat_im;
    logic [MW-1:0] mant_sh;
    logic signed [SHIFT_W-1:0] r_next;

    assign en       = !vld_reg[LAST] || m_tready;
    assign s_tready = en;
    assign in_re    = s_tdata[W-1:0];
    assign in_im    = s_tdata[2*W-1:W];
    assign mag_re_in = in_re[W-1] ? -in_re : in_re;
    assign mag_im_in = in_im[W-1] ? -in_im : in_im;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mre_reg[0] <= mag_re_in;
            mim_reg[0] <= mag_im_in;
            nre_reg[0] <= in_re[W-1];
            nim_reg[0] <= in_im[W-1];
            zer_reg[0] <= (in_re == '0) && (in_im == '0);
            exp_reg[0] <= s_tuser[0];
            for (int i = 1; i <= 56; i++) begin
                mre_reg[i] <= mre_reg[i-1];
                mim_reg[i] <= mim_reg[i-1];
                nre_reg[i] <= nre_reg[i-1];
                nim_reg[i] <= nim_reg[i-1];
                zer_reg[i] <= zer_reg[i-1];
                exp_reg[i] <= exp_reg[i-1];
            end
        end
    end

    always_comb begin
        v_or   = 64'(mre_reg[0] | mim_reg[0]);
        s_next = 6'd0;
        for (int i = 1; i <= SMAX; i++) begin
            if (v_or[30+i]) begin
                s_next = 6'(i);
            end
        end
        a_ext  = 64'(mre_reg[0]) >> s_next;
        b_ext  = 64'(mim_reg[0]) >> s_next;
        n_next = 6'd0;
        for (int i = 0; i < 63; i++) begin
            if (p2_reg[i]) begin
                n_next = 6'(i);
            end
        end
        y_next = n3_reg >= 6'(MANT_FRAC)
               ? MANT_W'(p3_reg >> (n3_reg - 6'(MANT_FRAC)))
               : MANT_W'(p3_reg << (6'(MANT_FRAC) - n3_reg));
        lint_next = LINT_W'($signed({2'b00, n3_reg}) + $signed({1'b0, s3_reg, 1'b0}) - 32);
        lval   = $signed({lint_reg[28], fr_c[NCELL]});
        z_next = 64'(lval) * 64'(exp_reg[28] ? EXP_EXPAND : EXP_COMPRESS);
        g_next = 64'(z_reg) + (64'd1 << 56) + (64'd1 << (LOG_FRAC - 1));
        mant_sh = MW'(m_c[NCELL] >> MSH);
        r_next  = SHIFT_W'(MANT_FRAC - MSH) - k_reg[54];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg <= a_ext[MANT_W-1:0];
            b1_reg <= b_ext[MANT_W-1:0];
            s1_reg <= s_next;
            p2_reg <= 63'(a1_reg) * 63'(a1_reg) + 63'(b1_reg) * 63'(b1_reg);
            s2_reg <= s1_reg;
            p3_reg <= p2_reg;
            n3_reg <= n_next;
            s3_reg <= s2_reg;
            y4_reg <= y_next;
            lint_reg[4] <= lint_next;
            for (int i = 5; i <= 28; i++) begin
                lint_reg[i] <= lint_reg[i-1];
            end
            z_reg   <= z_next;
            k_reg[30] <= SHIFT_W'($signed({2'b00, g_next[63:48]}) - 256);
            f30_reg <= g_next[47:24];
            for (int i = 31; i <= 54; i++) begin
                k_reg[i] <= k_reg[i-1];
            end
            orr_reg  <= zer_reg[56] ? '0 : part_re;
            oim_reg  <= zer_reg[56] ? '0 : part_im;
            osat_reg <= !zer_reg[56] && (sat_re || sat_im);
        end
    end

    assign y_c[0]  = y4_reg;
    assign fr_c[0] = '0;
    assign m_c[0]  = MANT_W'(64'd1 << MANT_FRAC);
    assign fe_c[0] = f30_reg;

    for (genvar j = 0; j < NCELL; j++) begin : g_log
        spl_log_cell u_log (
            .aclk     (aclk),
            .en       (en),
            .y_in     (y_c[j]),
            .frac_in  (fr_c[j]),
            .y_out    (y_c[j+1]),
            .frac_out (fr_c[j+1])
        );
    end

    for (genvar j = 0; j < NCELL; j++) begin : g_exp
        spl_exp_cell #(.IDX(j + 1)) u_exp (
            .aclk  (aclk),
            .en    (en),
            .m_in  (m_c[j]),
            .f_in  (fe_c[j]),
            .m_out (m_c[j+1]),
            .f_out (fe_c[j+1])
        );
    end

    spl_scale #(.SAMPLE_WIDTH(W), .MW(MW)) u_scale_re (
        .aclk (aclk),
        .en   (en),
        .mag  (mre_reg[54]),
        .neg  (nre_reg[54]),
        .mant (mant_sh),
        .rsh  (r_next),
        .part (part_re),
        .sat  (sat_re)
    );

    spl_scale #(.SAMPLE_WIDTH(W), .MW(MW)) u_scale_im (
        .aclk (aclk),
        .en   (en),
        .mag  (mim_reg[54]),
        .neg  (nim_reg[54]),
        .mant (mant_sh),
        .rsh  (r_next),
        .part (part_im),
        .sat  (sat_im)
    );

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = TDW'({oim_reg, orr_reg});
    assign m_tuser  = {7'd0, osat_reg};

    `ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid straight after reset")
    `ASSERT_CLK(a_sat_at_limit,
        m_tvalid && m_tuser[0] |-> orr_reg == {1'b0, {(W-1){1'b1}}} ||
        orr_reg == {1'b1, {(W-1){1'b0}}} || oim_reg == {1'b0, {(W-1){1'b1}}} ||
        oim_reg == {1'b1, {(W-1){1'b0}}}, "saturated flag without a clipped part")
    `ASSERT_CLK(a_zero_bin, en && vld_reg[56] && zer_reg[56] |=> m_tdata == '0 && m_tuser == '0,
        "zero bin gave a nonzero result")
endmodule

// File: tb/sv/spl_compander_checker.sv
// Checker for the spectral power-law compander: watches both stream channels,
// predicts each result from the accepted input word and compares field by field.
// Depends on spl_pkg only for the default sample width.
module spl_compander_checker #(
    parameter int SW = spl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((2*SW+7)/8)*8-1:0]           s_tdata,
    input  logic [7:0]                          s_tuser,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [((2*SW+7)/8)*8-1:0]           m_tdata,
    input  logic [7:0]                          m_tuser,
    output int                                  fail_count,
    output int                                  pending
);
    localparam int LFRAC = 24;
    localparam int MFRAC = 30;
    localparam longint EXP_CMP = -64'sd5872026;
    localparam longint EXP_EXP = 64'sd19573419;

    typedef struct packed {
        logic [SW-1:0] re;
        logic [SW-1:0] im;
        logic          sat;
    } bin_result_t;

    bin_result_t scaled_bins[$];

    function automatic logic [63:0] root_trunc(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = val;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] scale_mag(input logic [63:0] mag, input logic neg,
                                              input logic [63:0] mant, input longint sh,
                                              inout logic sat);
        logic [63:0] lim;
        logic [63:0] prod;
        logic [63:0] q;
        longint l;
        lim = neg ? (64'd1 << (SW-1)) : (64'd1 << (SW-1)) - 1;
        prod = mag * mant;
        if (sh > 0) begin
            if (sh > 63) q = 0;
            else q = (prod + (64'd1 << (sh-1))) >> sh;
        end else begin
            l = -sh;
            if (prod == 0) q = 0;
            else if (l >= 63 || prod > (lim >> l)) q = lim + 1;
            else q = prod << l;
        end
        if (q > lim) begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? -q : q;
    endfunction

    function automatic bin_result_t compand_bin(input logic expand, input logic [SW-1:0] re,
                                                input logic [SW-1:0] im);
        bin_result_t res;
        logic [63:0] mre, mim, a, b, p, y, frac, g, c, mant, fr;
        longint s, n, lg, z, k, sh, msh;
        logic sat;
        mre = re[SW-1] ? (64'd1 << SW) - 64'(re) : 64'(re);
        mim = im[SW-1] ? (64'd1 << SW) - 64'(im) : 64'(im);
        res = '0;
        if (mre == 0 && mim == 0) return res;
        a = mre;
        b = mim;
        s = 0;
        while (((a | b) >> 31) != 0) begin
            a = a >> 1;
            b = b >> 1;
            s++;
        end
        p = a * a + b * b;
        n = 0;
        while ((p >> n) > 1) n++;
        y = n >= MFRAC ? p >> (n - MFRAC) : p << (MFRAC - n);
        frac = 0;
        for (int i = 0; i < LFRAC; i++) begin
            y = (y * y) >> MFRAC;
            frac = frac << 1;
            if (y >= (64'd1 << (MFRAC+1))) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        lg = (n + 2*s - 32) * (64'sd1 << LFRAC) + longint'(frac);
        z = lg * (expand ? EXP_EXP : EXP_CMP);
        g = (64'(z + (64'sd1 << 56)) + (64'd1 << (LFRAC-1))) >> LFRAC;
        k = longint'(g >> LFRAC) - 256;
        fr = g & ((64'd1 << LFRAC) - 1);
        c = 64'd1 << (MFRAC+1);
        mant = 64'd1 << MFRAC;
        for (int i = 1; i <= LFRAC; i++) begin
            c = root_trunc(c << MFRAC);
            if ((fr >> (LFRAC - i)) & 1)
                mant = (mant * c + (64'd1 << (MFRAC-1))) >> MFRAC;
        end
        msh = SW > 32 ? SW - 32 : 0;
        mant = mant >> msh;
        sh = (MFRAC - msh) - k;
        sat = 1'b0;
        res.re = SW'(scale_mag(mre, re[SW-1], mant, sh, sat));
        res.im = SW'(scale_mag(mim, im[SW-1], mant, sh, sat));
        res.sat = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && s_tvalid && s_tready)
            scaled_bins.push_back(compand_bin(s_tuser[0], s_tdata[SW-1:0],
                                              s_tdata[2*SW-1:SW]));
        if (aresetn && m_tvalid && m_tready) begin
            if (scaled_bins.size() == 0) begin
                report_mismatch("unexpected word", 64'(m_tdata), 64'd0);
            end else begin
                want = scaled_bins.pop_front();
                if (m_tdata[SW-1:0] !== want.re)
                    report_mismatch("out_re", 64'(m_tdata[SW-1:0]), 64'(want.re));
                if (m_tdata[2*SW-1:SW] !== want.im)
                    report_mismatch("out_im", 64'(m_tdata[2*SW-1:SW]), 64'(want.im));
                if (m_tuser[0] !== want.sat)
                    report_mismatch("saturated", 64'(m_tuser[0]), 64'(want.sat));
            end
        end
        pending = scaled_bins.size();
    end
endmodule

// File: tb/sv/tb_spectral_power_law_compander.sv
// Testbench top for the spectral power-law compander: drives bins with random gaps
// and output stalls. Depends on spl_compander_checker and the compander RTL.
module tb_spectral_power_law_compander;
    localparam int SW = 32;
    localparam int DW = ((2*SW+7)/8)*8;
    localparam int WATCHDOG = 20000;

    logic          aclk = 0;
    logic          aresetn = 0;
    logic          s_tvalid = 0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic [7:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 0;
    logic [DW-1:0] m_tdata;
    logic [7:0]    m_tuser;
    int            fail_count;
    int            pending;
    int            idle_cycles = 0;
    logic          calm = 0;

    always #6 aclk = ~aclk;

    spectral_power_law_compander #(.SAMPLE_WIDTH(SW)) dut (.*);

    spl_compander_checker #(.SW(SW)) checker_i (.*);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("spectral_power_law_compander test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 23);
    end

    function automatic logic [SW-1:0] pick_part();
        case ($urandom_range(7))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return '0;
            3: return SW'($urandom_range(0, 1 << 20)) - SW'(1 << 19);
            4: return SW'($urandom_range(0, 1 << 10)) - SW'(1 << 9);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic send_bin(input logic fn, input logic [SW-1:0] re, input logic [SW-1:0] im);
        while (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= DW'({im, re});
        s_tuser <= {7'd0, fn};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin
        logic [SW-1:0] edge_vals[6];
        int tail;
        edge_vals = '{'0, 1, -1, {1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}}, SW'(1 << 16)};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < 6; i++) begin
            send_bin(i[0], edge_vals[i], edge_vals[5-i]);
            send_bin(~i[0], edge_vals[i], edge_vals[i]);
        end
        send_bin(1'b1, SW'(1 << 20), '0);
        send_bin(1'b0, '0, SW'(3));
        for (int i = 0; i < 1300; i++) begin
            calm = (i >= 500 && i < 700);
            send_bin($urandom_range(1), pick_part(), pick_part());
        end
        calm = 0;
        s_tvalid <= 1'b0;
        tail = 0;
        while (pending != 0 && tail < 200000) begin
            @(posedge aclk);
            tail++;
        end
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("spectral_power_law_compander test passed");
        else
            $display("spectral_power_law_compander test failed");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/spl_pkg.sv
sv/spl_log_cell.sv
sv/spl_exp_cell.sv
sv/spl_scale.sv
sv/spectral_power_law_compander.sv
tb/sv/spl_compander_checker.sv
tb/sv/tb_spectral_power_law_compander.sv
